// File: hw/rtl/glc_pkg.sv
// Package for the grid label compactor: payload structs, code constants,
// control word fields and the microcode ROM. No dependencies.
`default_nettype none

package glc_pkg;

  localparam int MAX_IDS = 1024;
  localparam int IDX_W   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CODE_W  = 11;
  localparam int DEC_W   = (IDX_W > CODE_W) ? IDX_W : CODE_W;
  localparam int UPC_W   = 5;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_IDS - 1);

  // Cell code offset encoding.
  localparam logic [CODE_W-1:0] BASE_CODE = CODE_W'(32);
  localparam logic [CODE_W-1:0] SKIP_LOW  = CODE_W'(34);
  localparam logic [CODE_W-1:0] SKIP_HIGH = CODE_W'(92);

  // Commands.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_REMAP = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOT_ID = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [CODE_W-1:0] cell_code;
  } in_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] new_code;
    logic [CODE_W-1:0] kept_count;
    logic [1:0]        status;
  } out_rsp_t;

  // One id store entry: used mark plus rank.
  typedef struct packed {
    logic              mark;
    logic [CODE_W-1:0] rank;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // Branch conditions.
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_REQ, C_IS_CLEAR, C_IS_REMAP, C_DEC_BAD,
    C_MARKED, C_NOT_LAST, C_READY, C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {RD_NONE, RD_ID, RD_WALK} rd_t;
  typedef enum logic [1:0] {WR_NONE, WR_ZERO_WALK, WR_MARK_ID, WR_RANK_WALK} wr_t;
  typedef enum logic [1:0] {W_HOLD, W_ZERO, W_INC} walk_t;
  typedef enum logic [1:0] {T_HOLD, T_ZERO, T_INC} total_t;
  typedef enum logic [1:0] {R_HOLD, R_CLR, R_SET} ready_t;
  typedef enum logic [1:0] {RES_NONE, RES_PASS, RES_REMAP, RES_CLEAR} res_t;

  typedef struct packed {
    logic             in_ready;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    rd_t              rd;
    wr_t              wr;
    walk_t            walk;
    total_t           total;
    ready_t           ready;
    res_t             res;
    logic             emit;
  } ctrl_t;

  // Flags from datapath back to the sequencer.
  typedef struct packed {
    logic req;
    logic is_clear;
    logic is_remap;
    logic dec_bad;
    logic marked;
    logic not_last;
    logic ready;
    logic out_busy;
  } flags_t;

  // Program addresses.
  localparam logic [UPC_W-1:0] S_BOOT      = 5'd0;
  localparam logic [UPC_W-1:0] S_BOOT_CLR  = 5'd1;
  localparam logic [UPC_W-1:0] S_WAIT      = 5'd2;
  localparam logic [UPC_W-1:0] S_DISP_CLR  = 5'd3;
  localparam logic [UPC_W-1:0] S_DISP_RMP  = 5'd4;
  localparam logic [UPC_W-1:0] S_MARK_CHK  = 5'd5;
  localparam logic [UPC_W-1:0] S_MARK_RD   = 5'd6;
  localparam logic [UPC_W-1:0] S_MARK_TST  = 5'd7;
  localparam logic [UPC_W-1:0] S_MARK_WR   = 5'd8;
  localparam logic [UPC_W-1:0] S_REMAP     = 5'd9;
  localparam logic [UPC_W-1:0] S_BUILD_RD  = 5'd10;
  localparam logic [UPC_W-1:0] S_BUILD_WR  = 5'd11;
  localparam logic [UPC_W-1:0] S_LOOKUP    = 5'd12;
  localparam logic [UPC_W-1:0] S_LOOKUP_RD = 5'd13;
  localparam logic [UPC_W-1:0] S_LOOKUP_EV = 5'd14;
  localparam logic [UPC_W-1:0] S_OUT_WAIT  = 5'd15;
  localparam logic [UPC_W-1:0] S_EMIT      = 5'd16;
  localparam logic [UPC_W-1:0] S_CLEAR     = 5'd17;
  localparam logic [UPC_W-1:0] S_CLEAR_WR  = 5'd18;
  localparam logic [UPC_W-1:0] S_CLEAR_END = 5'd19;

  // Microcode ROM. Branch to target when cond holds, else fall through.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] step);
    ctrl_t w;
    w        = '0;
    w.cond   = C_NEVER;
    w.target = S_BOOT;
    unique case (step)
      S_BOOT: begin
        w.walk = W_ZERO; w.total = T_ZERO; w.ready = R_CLR;
      end
      S_BOOT_CLR: begin
        w.wr = WR_ZERO_WALK; w.walk = W_INC;
        w.cond = C_NOT_LAST; w.target = S_BOOT_CLR;
      end
      S_WAIT: begin
        w.in_ready = 1'b1; w.cond = C_NO_REQ; w.target = S_WAIT;
      end
      S_DISP_CLR: begin
        w.cond = C_IS_CLEAR; w.target = S_CLEAR;
      end
      S_DISP_RMP: begin
        w.cond = C_IS_REMAP; w.target = S_REMAP;
      end
      S_MARK_CHK: begin
        w.res = RES_PASS; w.cond = C_DEC_BAD; w.target = S_OUT_WAIT;
      end
      S_MARK_RD: begin
        w.rd = RD_ID;
      end
      S_MARK_TST: begin
        w.cond = C_MARKED; w.target = S_OUT_WAIT;
      end
      S_MARK_WR: begin
        w.wr = WR_MARK_ID; w.total = T_INC; w.ready = R_CLR;
        w.cond = C_ALWAYS; w.target = S_OUT_WAIT;
      end
      S_REMAP: begin
        w.res = RES_PASS; w.walk = W_ZERO;
        w.cond = C_READY; w.target = S_LOOKUP;
      end
      S_BUILD_RD: begin
        w.rd = RD_WALK;
      end
      S_BUILD_WR: begin
        w.wr = WR_RANK_WALK; w.walk = W_INC;
        w.cond = C_NOT_LAST; w.target = S_BUILD_RD;
      end
      S_LOOKUP: begin
        w.ready = R_SET; w.cond = C_DEC_BAD; w.target = S_OUT_WAIT;
      end
      S_LOOKUP_RD: begin
        w.rd = RD_ID;
      end
      S_LOOKUP_EV: begin
        w.res = RES_REMAP; w.cond = C_ALWAYS; w.target = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        w.cond = C_OUT_BUSY; w.target = S_OUT_WAIT;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.cond = C_ALWAYS; w.target = S_WAIT;
      end
      S_CLEAR: begin
        w.res = RES_CLEAR; w.walk = W_ZERO; w.total = T_ZERO; w.ready = R_CLR;
      end
      S_CLEAR_WR: begin
        w.wr = WR_ZERO_WALK; w.walk = W_INC;
        w.cond = C_NOT_LAST; w.target = S_CLEAR_WR;
      end
      S_CLEAR_END: begin
        w.cond = C_ALWAYS; w.target = S_OUT_WAIT;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_BOOT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/glc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module glc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/glc_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional branch.
// Depends on glc_pkg.
`default_nettype none

module glc_seq
  import glc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output      ctrl_t  ctrl
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             take;

  assign ctrl = ucode(upc_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_REQ:   take = !flags.req;
      C_IS_CLEAR: take = flags.is_clear;
      C_IS_REMAP: take = flags.is_remap;
      C_DEC_BAD:  take = flags.dec_bad;
      C_MARKED:   take = flags.marked;
      C_NOT_LAST: take = flags.not_last;
      C_READY:    take = flags.ready;
      C_OUT_BUSY: take = flags.out_busy;
      default:    take = 1'b0;
    endcase
    upc_nxt = take ? ctrl.target : upc_r + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_BOOT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/glc_dp.sv
// Datapath: request latch, code decode/encode, walk and rank counters,
// id store, result register. Depends on glc_pkg and glc_ram.
`default_nettype none

module glc_dp
  import glc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ctrl_t    ctrl,
  output      flags_t   flags,
  input  wire logic     in_valid,
  input  wire in_req_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      out_rsp_t out_data
);

  logic [1:0]        cmd_r;
  logic [CODE_W-1:0] code_r;
  logic [IDX_W-1:0]  walk_r, walk_nxt;
  logic [CODE_W-1:0] rank_r, rank_nxt;
  logic [CODE_W-1:0] total_r, total_nxt;
  logic              ready_r, ready_nxt;
  logic [CODE_W-1:0] res_code_r, res_code_nxt;
  logic [1:0]        res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_r, out_nxt;

  // decode
  logic [CODE_W-1:0] step1, step2, adj11;
  logic [DEC_W-1:0]  adj, adj_m1;
  logic [1:0]        dec_stat;
  logic [IDX_W-1:0]  id_idx;

  // id store
  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  ent_t              wdata, rdata;

  // encode
  logic [CODE_W-1:0] enc0, enc1, enc2;

  always_comb begin
    step1  = code_r - ((code_r >= SKIP_HIGH) ? CODE_W'(1) : CODE_W'(0));
    step2  = step1 - ((step1 >= SKIP_LOW) ? CODE_W'(1) : CODE_W'(0));
    adj11  = step2 - BASE_CODE;
    adj    = DEC_W'(adj11);
    adj_m1 = adj - DEC_W'(1);
    id_idx = adj_m1[IDX_W-1:0];
    if (code_r < BASE_CODE || code_r == SKIP_LOW || code_r == SKIP_HIGH) begin
      dec_stat = ST_NOT_ID;
    end else if (adj == '0) begin
      dec_stat = ST_NOT_ID;
    end else if ({1'b0, adj} > (DEC_W + 1)'(MAX_IDS)) begin
      dec_stat = ST_RANGE;
    end else begin
      dec_stat = ST_OK;
    end
  end

  always_comb begin
    enc0 = rdata.rank + BASE_CODE;
    enc1 = enc0 + ((enc0 >= SKIP_LOW) ? CODE_W'(1) : CODE_W'(0));
    enc2 = enc1 + ((enc1 >= SKIP_HIGH) ? CODE_W'(1) : CODE_W'(0));
  end

  always_comb begin
    flags.req      = in_valid;
    flags.is_clear = (cmd_r == CMD_CLEAR);
    flags.is_remap = (cmd_r == CMD_REMAP);
    flags.dec_bad  = (cmd_r != CMD_MARK && cmd_r != CMD_REMAP) || (dec_stat != ST_OK);
    flags.marked   = rdata.mark;
    flags.not_last = (walk_r != IDX_LAST);
    flags.ready    = ready_r;
    flags.out_busy = out_valid_r && !out_ready;
  end

  // id store port control
  always_comb begin
    re    = (ctrl.rd != RD_NONE);
    raddr = (ctrl.rd == RD_WALK) ? walk_r : id_idx;
    we    = 1'b0;
    waddr = walk_r;
    wdata = '0;
    rank_nxt = rank_r;
    case (ctrl.wr)
      WR_ZERO_WALK: begin
        we = 1'b1;
      end
      WR_MARK_ID: begin
        we         = 1'b1;
        waddr      = id_idx;
        wdata.mark = 1'b1;
      end
      WR_RANK_WALK: begin
        if (rdata.mark) begin
          rank_nxt   = rank_r + CODE_W'(1);
          we         = 1'b1;
          wdata.mark = 1'b1;
          wdata.rank = rank_r + CODE_W'(1);
        end
      end
      default: ;
    endcase
    // a walk restart also restarts the rank count
    if (ctrl.walk == W_ZERO) begin
      rank_nxt = '0;
    end
  end

  always_comb begin
    case (ctrl.walk)
      W_ZERO:  walk_nxt = '0;
      W_INC:   walk_nxt = walk_r + IDX_W'(1);
      default: walk_nxt = walk_r;
    endcase
    case (ctrl.total)
      T_ZERO:  total_nxt = '0;
      T_INC:   total_nxt = total_r + CODE_W'(1);
      default: total_nxt = total_r;
    endcase
    case (ctrl.ready)
      R_CLR:   ready_nxt = 1'b0;
      R_SET:   ready_nxt = 1'b1;
      default: ready_nxt = ready_r;
    endcase
    res_code_nxt = res_code_r;
    res_stat_nxt = res_stat_r;
    case (ctrl.res)
      RES_PASS: begin
        res_code_nxt = code_r;
        res_stat_nxt = (cmd_r == CMD_MARK || cmd_r == CMD_REMAP) ? dec_stat : ST_NOT_ID;
      end
      RES_REMAP: begin
        res_code_nxt = rdata.mark ? enc2 : code_r;
        res_stat_nxt = rdata.mark ? ST_OK : ST_RANGE;
      end
      RES_CLEAR: begin
        res_code_nxt = code_r;
        res_stat_nxt = ST_OK;
      end
      default: ;
    endcase
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (ctrl.emit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.new_code   = res_code_r;
      out_nxt.kept_count = total_r;
      out_nxt.status     = res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= '0;
      rank_r      <= '0;
      total_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      walk_r      <= walk_nxt;
      rank_r      <= rank_nxt;
      total_r     <= total_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (ctrl.in_ready && in_valid) begin
      cmd_r  <= in_data.command;
      code_r <= in_data.cell_code;
    end
    res_code_r <= res_code_nxt;
    res_stat_r <= res_stat_nxt;
    out_r      <= out_nxt;
  end

  glc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_IDS)
  ) u_ids (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: hw/rtl/grid_label_compactor.sv
// Top level of the grid label compactor: sequencer plus datapath.
// Depends on glc_pkg, glc_seq, glc_dp (and glc_ram through glc_dp).
`default_nettype none

// Grid label compactor. Each request carries a command and an 11-bit cell
// code (id + 32, with codes 34 and 92 skipped; code 32 is background) and
// yields exactly one result: new code, kept id count and status. Clear
// empties the used-id set, mark flags a cell's id as used, remap returns the
// encoded dense rank of the id among the used ids. Control is a small
// microcode program driving one id store RAM (mark bit plus rank per id,
// one write and one registered read per cycle), so requests are handled one
// at a time. Clear zeroes one store entry per cycle, and the first remap
// after any new mark or a clear walks the store to rebuild ranks, reading
// and then writing each id. After reset the store is zeroed in a clearing
// pass during which in_ready stays low. A finished result sits in the
// output register, so the next request is taken while it waits.
module grid_label_compactor
  import glc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire in_req_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      out_rsp_t out_data
);

  ctrl_t  ctrl;
  flags_t flags;

  // in_ready is a control-word bit: high only in the wait step
  assign in_ready = ctrl.in_ready;

  glc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  glc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: test/glc_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the grid label compactor: keeps its own id store, predicts
// each result from the accepted requests and compares field by field.
// Depends on glc_pkg only.
module glc_result_checker
  import glc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_rsp_t out_data,
  output int       fail_count,
  output int       pending
);

  bit                id_used [MAX_IDS];
  logic [CODE_W-1:0] id_rank [MAX_IDS];
  bit                ranks_valid;
  logic [CODE_W-1:0] kept_ids;
  out_rsp_t          expected_results[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Status of a cell code; id gets the decoded id when the status is ok.
  function automatic logic [1:0] decode_cell(input logic [CODE_W-1:0] code, output int id);
    int c;
    c  = int'(code);
    id = 0;
    if (code < BASE_CODE || code == SKIP_LOW || code == SKIP_HIGH)
      return ST_NOT_ID;
    if (c >= int'(SKIP_HIGH))
      c--;
    if (c >= int'(SKIP_LOW))
      c--;
    c -= int'(BASE_CODE);
    if (c == 0)
      return ST_NOT_ID;
    if (c > MAX_IDS)
      return ST_RANGE;
    id = c;
    return ST_OK;
  endfunction

  function automatic logic [CODE_W-1:0] encode_rank(input logic [CODE_W-1:0] rank);
    int c;
    c = int'(rank) + int'(BASE_CODE);
    if (c >= int'(SKIP_LOW))
      c++;
    if (c >= int'(SKIP_HIGH))
      c++;
    return CODE_W'(c);
  endfunction

  // Applies one request to the local id store and returns its result.
  function automatic out_rsp_t compact_label(input in_req_t req);
    out_rsp_t   rsp;
    logic [1:0] st;
    int         id;
    int         r;
    rsp.new_code = req.cell_code;
    st = ST_NOT_ID;
    case (req.command)
      CMD_CLEAR: begin
        foreach (id_used[i])
          id_used[i] = 1'b0;
        kept_ids    = '0;
        ranks_valid = 1'b0;
        st          = ST_OK;
      end
      CMD_MARK: begin
        st = decode_cell(req.cell_code, id);
        if (st == ST_OK && !id_used[id-1]) begin
          id_used[id-1] = 1'b1;
          kept_ids++;
          ranks_valid = 1'b0;
        end
      end
      CMD_REMAP: begin
        if (!ranks_valid) begin
          r = 0;
          foreach (id_used[i]) begin
            if (id_used[i]) begin
              r++;
              id_rank[i] = CODE_W'(r);
            end
          end
          ranks_valid = 1'b1;
        end
        st = decode_cell(req.cell_code, id);
        if (st == ST_OK) begin
          if (id_used[id-1])
            rsp.new_code = encode_rank(id_rank[id-1]);
          else
            st = ST_RANGE;
        end
      end
      default: st = ST_NOT_ID;
    endcase
    rsp.kept_count = kept_ids;
    rsp.status     = st;
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      foreach (id_used[i])
        id_used[i] = 1'b0;
      ranks_valid = 1'b0;
      kept_ids    = '0;
      expected_results.delete();
    end else begin
      // result side first: it always belongs to an older request
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding, new_code",
                          out_data.new_code, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.new_code !== want.new_code)
            report_mismatch("new_code", out_data.new_code, want.new_code);
          if (out_data.kept_count !== want.kept_count)
            report_mismatch("kept_count", out_data.kept_count, want.kept_count);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(compact_label(in_data));
    end
    pending = expected_results.size();
  end

endmodule

// File: test/grid_label_compactor_test.sv
`timescale 1ns / 1ps
// Testbench top for the grid label compactor: clock, reset, request stimulus,
// result-side backpressure and the verdict. Depends on glc_pkg,
// glc_result_checker and the grid_label_compactor RTL.
module grid_label_compactor_test;
  import glc_pkg::*;

  // Command value the block does not define; it must pass the code through.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int FIRST_CODE  = int'(BASE_CODE) + 1;  // id 1
  localparam int TOP_CODE    = MAX_IDS + 34;         // highest id, both skips applied
  localparam int ANY_CODE    = (1 << CODE_W) - 1;
  localparam int ITEM_TARGET = 1500;                 // includes one full-store grid
  localparam int QUIET_ITEMS = 250;                  // tail run with no idling
  localparam int HOLD_GRID   = 2;                    // grid with the long result stall
  localparam int FULL_GRID   = 7;                    // grid that marks every id
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 2 * MAX_IDS + 16;     // worst rebuild latency plus slack
  // every request a full rank rebuild plus idling, with a wide margin
  localparam int CYCLE_LIMIT = 4 * ITEM_TARGET * (2 * MAX_IDS + 64);

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_data;

  int fail_count;
  int pending;

  int items_sent;
  int gap_pct;
  bit quiet;
  bit hold_request;
  int lo;
  int hi;
  logic [CODE_W-1:0] marked_codes[$];

  grid_label_compactor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  glc_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("grid_label_compactor verification failed");
    $finish;
  end

  // Result side. Mostly ready in stretches of varying length, with random
  // stall bursts; once, a long stall so the output register fills, the next
  // result is held back and in_ready drops while requests keep coming.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        n = LONG_HOLD;
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 15);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  function automatic logic [CODE_W-1:0] window_code();
    return CODE_W'($urandom_range(lo, hi));
  endfunction

  function automatic logic [CODE_W-1:0] any_code();
    return CODE_W'($urandom_range(0, ANY_CODE));
  endfunction

  function automatic logic [CODE_W-1:0] marked_code();
    if (marked_codes.size() == 0)
      return window_code();
    return marked_codes[$urandom_range(0, marked_codes.size() - 1)];
  endfunction

  // Offers one request and returns at the falling edge after it was taken.
  // Called at a falling edge; valid stays up across back-to-back requests.
  task automatic send_request(input logic [1:0] cmd, input logic [CODE_W-1:0] code);
    in_req_t req;
    req.command   = cmd;
    req.cell_code = code;
    quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (cmd != CMD_UNUSED)
      items_sent++;
  endtask

  // Sender pause: nothing offered until every result is back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    int grid;
    int n_mark;
    int n_remap;
    int pick;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    items_sent   = 0;
    gap_pct      = 20;
    quiet        = 1'b0;
    hold_request = 1'b0;
    lo           = FIRST_CODE;
    hi           = TOP_CODE;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The first remap comes before any mark, so the rank
    // table is built from an empty store. The block's boot clear holds
    // in_ready low meanwhile; the handshake just waits.
    send_request(CMD_REMAP, BASE_CODE + CODE_W'(1));
    send_request(CMD_MARK, '0);                        // below the code range
    send_request(CMD_MARK, BASE_CODE - CODE_W'(1));
    send_request(CMD_MARK, BASE_CODE);                 // background
    send_request(CMD_MARK, SKIP_LOW);                  // skipped codes are not ids
    send_request(CMD_MARK, SKIP_HIGH);
    send_request(CMD_MARK, BASE_CODE + CODE_W'(1));    // id 1
    send_request(CMD_MARK, SKIP_LOW + CODE_W'(1));     // first id above the low skip
    send_request(CMD_MARK, SKIP_HIGH - CODE_W'(1));
    send_request(CMD_MARK, SKIP_HIGH + CODE_W'(1));    // first id above both skips
    send_request(CMD_MARK, CODE_W'(TOP_CODE));         // highest id
    send_request(CMD_MARK, CODE_W'(TOP_CODE + 1));     // one past the store
    send_request(CMD_MARK, CODE_W'(ANY_CODE));
    send_request(CMD_MARK, BASE_CODE + CODE_W'(1));    // already marked
    send_request(CMD_UNUSED, CODE_W'(ANY_CODE));
    send_request(CMD_REMAP, BASE_CODE + CODE_W'(1));   // rebuild after new marks
    send_request(CMD_REMAP, CODE_W'(TOP_CODE));
    send_request(CMD_REMAP, SKIP_HIGH + CODE_W'(1));
    send_request(CMD_REMAP, BASE_CODE);
    send_request(CMD_REMAP, SKIP_HIGH);
    send_request(CMD_REMAP, CODE_W'(TOP_CODE + 1));
    send_request(CMD_REMAP, SKIP_LOW + CODE_W'(2));    // valid id, never marked
    send_request(CMD_REMAP, '0);
    send_request(CMD_CLEAR, CODE_W'(ANY_CODE));
    send_request(CMD_REMAP, CODE_W'(TOP_CODE));        // store empty after clear
    wait_results_drained();

    // Random part, shaped like real grids: clear, a mark pass over cells
    // drawn from a window of ids, then a remap pass mostly over the cells
    // that were marked. A little noise in each pass: stray codes, unused
    // commands, marks during the remap pass (forcing a rebuild), clears.
    grid = 0;
    while (items_sent < ITEM_TARGET) begin
      grid++;
      if (grid % 6 == 3)
        wait_results_drained();
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      marked_codes.delete();
      send_request(CMD_CLEAR, any_code());

      if (grid == FULL_GRID) begin
        // every id in the store, so the count and the rank reach their top
        lo = FIRST_CODE;
        hi = TOP_CODE;
        for (int c = FIRST_CODE; c <= TOP_CODE; c++) begin
          send_request(CMD_MARK, CODE_W'(c));
          marked_codes.push_back(CODE_W'(c));
        end
        send_request(CMD_REMAP, CODE_W'(TOP_CODE));
      end else begin
        lo = $urandom_range(FIRST_CODE, TOP_CODE);
        hi = lo + $urandom_range(0, 200);
        if (hi > TOP_CODE)
          hi = TOP_CODE;
        n_mark = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                             : $urandom_range(1, 40);
        if (grid == HOLD_GRID && n_mark < 20)
          n_mark = 20;
        for (int k = 0; k < n_mark; k++) begin
          if (grid == HOLD_GRID && k == 3)
            hold_request = 1'b1;
          pick = $urandom_range(0, 99);
          if (pick < 85) begin
            marked_codes.push_back(window_code());
            send_request(CMD_MARK, marked_codes[$]);
          end else if (pick < 90) begin
            send_request(CMD_MARK, any_code());
          end else if (pick < 94) begin
            send_request(CMD_MARK, marked_code());
          end else if (pick < 97) begin
            send_request(CMD_UNUSED, any_code());
          end else begin
            send_request(CMD_REMAP, window_code());
          end
        end
      end

      n_remap = $urandom_range(5, 60);
      for (int k = 0; k < n_remap; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_request(CMD_REMAP, marked_code());
        end else if (pick < 88) begin
          send_request(CMD_REMAP, window_code());
        end else if (pick < 93) begin
          send_request(CMD_REMAP, any_code());
        end else if (pick < 96) begin
          marked_codes.push_back(window_code());
          send_request(CMD_MARK, marked_codes[$]);
        end else if (pick < 98) begin
          send_request(CMD_UNUSED, any_code());
        end else begin
          marked_codes.delete();
          send_request(CMD_CLEAR, any_code());
        end
      end
    end

    // All requests are in; wait for the results, then watch a while longer
    // for anything the block might still emit.
    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("grid_label_compactor verification clean");
    else
      $display("grid_label_compactor verification failed");
    $finish;
  end

endmodule
